### hw/rtl/crt_congruence_merge_top_macros.svh
// Assertion macros for the congruence merge block.
// Used by the port checker; needs clk and rst_n in scope.
`ifndef CRT_CONGRUENCE_MERGE_TOP_MACROS_SVH
`define CRT_CONGRUENCE_MERGE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define CRTM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crtm check failed");

// next-cycle implication, checked outside reset
`define CRTM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crtm check failed");

`endif

### hw/rtl/crtm_pkg.sv
// Shared types and constants of the congruence merge block.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps

package crtm_pkg;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NOSOL = 2'd1;
    localparam logic [1:0] STATUS_OVF   = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_FIRST_DIV, ST_G0, ST_GLOOP, ST_R1G, ST_R2G, ST_M1G, ST_OVF,
        ST_NDIV, ST_AMOD, ST_BMOD, ST_DG, ST_DN, ST_U0, ST_EU, ST_EM, ST_ED,
        ST_TM, ST_TD, ST_RM, ST_WRITE
    } state_t;

endpackage

### hw/rtl/crtm_div.sv
// Bit-serial restoring divider: 64-bit dividend by 32-bit nonzero divisor.
// One quotient bit per cycle; standalone, no package use.
`timescale 1ns / 1ps

module crtm_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic [63:0] quo,
    output logic [31:0] rem,
    output logic        done
);

    logic [63:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dsr_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] shifted;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[63]};
        if (shifted >= {1'b0, dsr_reg})
        begin
            rem_next = 32'(shifted - {1'b0, dsr_reg});
            quo_next = {quo_reg[62:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[31:0];
            quo_next = {quo_reg[62:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

### hw/rtl/crtm_mul.sv
// Bit-serial shift-add multiplier: 64-bit by 32-bit, 96-bit product.
// One multiplier bit per cycle, LSB first; standalone, no package use.
`timescale 1ns / 1ps

module crtm_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [31:0] b,
    output logic [95:0] prod,
    output logic        done
);

    logic [63:0] mcand_reg;
    logic [31:0] mplier_reg;
    logic [63:0] hi_reg;
    logic [31:0] lo_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] sum;

    assign sum = {1'b0, hi_reg} + (mplier_reg[0] ? {1'b0, mcand_reg} : 65'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= a;
            mplier_reg <= b;
            hi_reg     <= '0;
            lo_reg     <= '0;
        end
        else if (busy_reg)
        begin
            // shift the partial sum right, one product bit into the low word
            hi_reg     <= sum[64:1];
            lo_reg     <= {sum[0], lo_reg[31:1]};
            mplier_reg <= {1'b0, mplier_reg[31:1]};
        end
    end

    assign prod = {hi_reg, lo_reg};
    assign done = done_reg;

endmodule

### hw/rtl/crt_congruence_merge_top.sv
// Top level of the running congruence merge (CRT with non-coprime moduli).
// Uses crtm_pkg, crtm_div and crtm_mul.
`timescale 1ns / 1ps

// Usage:
//  Input stream s_axis: tdata = {modulus, residue}, tuser = first (restart the
//  merge), tlast = last (echoed). One item is taken at a time; tready is high
//  only while the block is idle.
//  Output stream m_axis: one item per input item, tdata = {combined_modulus,
//  combined_residue}, tuser = status (0 ok, 1 no solution, 2 overflow, sticky
//  until an item with first), tlast = echo of the input last flag.
//  Operations: every mod, div and multiply runs on a bit-serial 64-step divider
//  or a 32-step multiplier. A restarting item needs one division, an item under
//  a sticky error none. A full merge runs the Euclid steps of the gcd and those
//  of the inverse; a no-solution item stops after the gcd and the residue
//  checks, an overflow item after the modulus multiply.
//  Reset clears the running congruence to 0 mod 1 and the status to ok.
//  A stalled output item holds; the next input item is accepted while it
//  waits, and its result waits until the held item is taken.
module crt_congruence_merge_top #(
    parameter int IN_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // [31:0] residue, [63:32] modulus
    input  logic         s_axis_tuser,   // [0] first
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // [63:0] combined_residue, [127:64] combined_modulus
    output logic [1:0]   m_axis_tuser,   // [1:0] status
    output logic         m_axis_tlast
);

    localparam logic [31:0] IN_MASK = 32'((64'd1 << IN_WIDTH) - 64'd1);

    crtm_pkg::state_t state_reg, state_next;

    logic [63:0] acc_r_reg, acc_m_reg;
    logic [1:0]  status_reg;
    logic [31:0] r2_reg, m2_reg;
    logic        last_reg;
    logic [31:0] ga_reg, gb_reg, tmp_reg, a_reg, d_reg, n_reg;
    logic [31:0] r0_reg, r1e_reg, q_reg, s0_reg, s1_reg, t_reg;
    logic [63:0] m1g_reg, lcm_reg;
    logic        launched_reg;

    logic        out_valid_reg;
    logic [63:0] out_r_reg, out_m_reg;
    logic [1:0]  out_status_reg;
    logic        out_last_reg;

    logic        div_start, div_done, mul_start, mul_done;
    logic [63:0] div_a, div_q, mul_a;
    logic [31:0] div_b, div_r, mul_b;
    logic [95:0] mul_p;
    logic        use_div, use_mul, skip;
    logic [31:0] in_r, in_m;
    logic        out_free;

    assign in_r     = s_axis_tdata[31:0] & IN_MASK;
    assign in_m     = s_axis_tdata[63:32] & IN_MASK;
    assign out_free = !out_valid_reg || m_axis_tready;

    crtm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quo      (div_q),
        .rem      (div_r),
        .done     (div_done)
    );

    crtm_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_p),
        .done  (mul_done)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crtm_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser)
                        state_next = crtm_pkg::ST_FIRST_DIV;
                    else if (status_reg != crtm_pkg::STATUS_OK)
                        state_next = crtm_pkg::ST_WRITE;
                    else
                        state_next = crtm_pkg::ST_G0;
                end
            end
            crtm_pkg::ST_FIRST_DIV: if (div_done) state_next = crtm_pkg::ST_WRITE;
            crtm_pkg::ST_G0:        if (div_done) state_next = crtm_pkg::ST_GLOOP;
            crtm_pkg::ST_GLOOP:
            begin
                if (gb_reg == 32'd0)
                    state_next = crtm_pkg::ST_R1G;
            end
            crtm_pkg::ST_R1G:       if (div_done) state_next = crtm_pkg::ST_R2G;
            crtm_pkg::ST_R2G:
            begin
                if (div_done)
                    state_next = (div_r != tmp_reg) ? crtm_pkg::ST_WRITE : crtm_pkg::ST_M1G;
            end
            crtm_pkg::ST_M1G:       if (div_done) state_next = crtm_pkg::ST_OVF;
            crtm_pkg::ST_OVF:
            begin
                if (mul_done)
                    state_next = (mul_p[95:64] != 32'd0) ? crtm_pkg::ST_WRITE
                                                         : crtm_pkg::ST_NDIV;
            end
            crtm_pkg::ST_NDIV:      if (div_done) state_next = crtm_pkg::ST_AMOD;
            crtm_pkg::ST_AMOD:      if (div_done) state_next = crtm_pkg::ST_BMOD;
            crtm_pkg::ST_BMOD:      if (div_done) state_next = crtm_pkg::ST_DG;
            crtm_pkg::ST_DG:
            begin
                if (div_done)
                    state_next = (n_reg <= 32'd1) ? crtm_pkg::ST_RM : crtm_pkg::ST_DN;
            end
            crtm_pkg::ST_DN:        if (div_done) state_next = crtm_pkg::ST_U0;
            crtm_pkg::ST_U0:        if (div_done) state_next = crtm_pkg::ST_EU;
            crtm_pkg::ST_EU:
            begin
                if (r1e_reg == 32'd0)
                    state_next = crtm_pkg::ST_TM;
                else if (div_done)
                    state_next = crtm_pkg::ST_EM;
            end
            crtm_pkg::ST_EM:        if (mul_done) state_next = crtm_pkg::ST_ED;
            crtm_pkg::ST_ED:        if (div_done) state_next = crtm_pkg::ST_EU;
            crtm_pkg::ST_TM:        if (mul_done) state_next = crtm_pkg::ST_TD;
            crtm_pkg::ST_TD:        if (div_done) state_next = crtm_pkg::ST_RM;
            crtm_pkg::ST_RM:        if (mul_done) state_next = crtm_pkg::ST_WRITE;
            crtm_pkg::ST_WRITE:     if (out_free) state_next = crtm_pkg::ST_IDLE;
            default:                state_next = crtm_pkg::ST_IDLE;
        endcase
    end

    // unit operands and launch
    always_comb
    begin
        use_div = 1'b0;
        use_mul = 1'b0;
        skip    = 1'b0;
        div_a   = '0;
        div_b   = 32'd1;
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            crtm_pkg::ST_FIRST_DIV: begin use_div = 1'b1; div_a = {32'd0, r2_reg};
                                          div_b = m2_reg; end
            crtm_pkg::ST_G0:   begin use_div = 1'b1; div_a = acc_m_reg; div_b = m2_reg; end
            crtm_pkg::ST_GLOOP:
            begin
                use_div = 1'b1;
                skip    = (gb_reg == 32'd0);
                div_a   = {32'd0, ga_reg};
                div_b   = gb_reg;
            end
            crtm_pkg::ST_R1G:  begin use_div = 1'b1; div_a = acc_r_reg; div_b = ga_reg; end
            crtm_pkg::ST_R2G:  begin use_div = 1'b1; div_a = {32'd0, r2_reg};
                                     div_b = ga_reg; end
            crtm_pkg::ST_M1G:  begin use_div = 1'b1; div_a = acc_m_reg; div_b = ga_reg; end
            crtm_pkg::ST_OVF:  begin use_mul = 1'b1; mul_a = m1g_reg; mul_b = m2_reg; end
            crtm_pkg::ST_NDIV: begin use_div = 1'b1; div_a = {32'd0, m2_reg};
                                     div_b = ga_reg; end
            crtm_pkg::ST_AMOD: begin use_div = 1'b1; div_a = acc_r_reg; div_b = m2_reg; end
            crtm_pkg::ST_BMOD: begin use_div = 1'b1; div_a = {32'd0, r2_reg};
                                     div_b = m2_reg; end
            crtm_pkg::ST_DG:   begin use_div = 1'b1; div_a = {32'd0, d_reg};
                                     div_b = ga_reg; end
            crtm_pkg::ST_DN:   begin use_div = 1'b1; div_a = {32'd0, tmp_reg};
                                     div_b = n_reg; end
            crtm_pkg::ST_U0:   begin use_div = 1'b1; div_a = m1g_reg; div_b = n_reg; end
            crtm_pkg::ST_EU:
            begin
                use_div = 1'b1;
                skip    = (r1e_reg == 32'd0);
                div_a   = {32'd0, r0_reg};
                div_b   = r1e_reg;
            end
            crtm_pkg::ST_EM:   begin use_mul = 1'b1; mul_a = {32'd0, q_reg}; mul_b = s1_reg; end
            crtm_pkg::ST_ED:   begin use_div = 1'b1; div_a = mul_p[63:0]; div_b = n_reg; end
            crtm_pkg::ST_TM:   begin use_mul = 1'b1; mul_a = {32'd0, tmp_reg};
                                     mul_b = s0_reg; end
            crtm_pkg::ST_TD:   begin use_div = 1'b1; div_a = mul_p[63:0]; div_b = n_reg; end
            crtm_pkg::ST_RM:   begin use_mul = 1'b1; mul_a = acc_m_reg; mul_b = t_reg; end
            default:           begin use_div = 1'b0; end
        endcase
        div_start = use_div && !launched_reg && !skip;
        mul_start = use_mul && !launched_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crtm_pkg::ST_IDLE;
            launched_reg  <= 1'b0;
            acc_r_reg     <= 64'd0;
            acc_m_reg     <= 64'd1;
            status_reg    <= crtm_pkg::STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_start || mul_start)
                launched_reg <= 1'b1;
            else if (div_done || mul_done)
                launched_reg <= 1'b0;

            case (state_reg)
                crtm_pkg::ST_FIRST_DIV:
                begin
                    if (div_done)
                    begin
                        acc_r_reg  <= {32'd0, div_r};
                        acc_m_reg  <= {32'd0, m2_reg};
                        status_reg <= crtm_pkg::STATUS_OK;
                    end
                end
                crtm_pkg::ST_R2G:
                begin
                    if (div_done && div_r != tmp_reg)
                        status_reg <= crtm_pkg::STATUS_NOSOL;
                end
                crtm_pkg::ST_OVF:
                begin
                    if (mul_done && mul_p[95:64] != 32'd0)
                        status_reg <= crtm_pkg::STATUS_OVF;
                end
                crtm_pkg::ST_RM:
                begin
                    if (mul_done)
                    begin
                        acc_r_reg <= acc_r_reg + mul_p[63:0];
                        acc_m_reg <= lcm_reg;
                    end
                end
                default:
                begin
                    acc_r_reg <= acc_r_reg;
                end
            endcase

            if (state_reg == crtm_pkg::ST_WRITE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == crtm_pkg::ST_IDLE && s_axis_tvalid)
        begin
            r2_reg   <= in_r;
            m2_reg   <= (in_m == 32'd0) ? 32'd1 : in_m;
            last_reg <= s_axis_tlast;
        end
        if (state_reg == crtm_pkg::ST_WRITE && out_free)
        begin
            out_r_reg      <= acc_r_reg;
            out_m_reg      <= acc_m_reg;
            out_status_reg <= status_reg;
            out_last_reg   <= last_reg;
        end
        if (div_done)
        begin
            case (state_reg)
                crtm_pkg::ST_G0:
                begin
                    ga_reg <= m2_reg;
                    gb_reg <= div_r;
                end
                crtm_pkg::ST_GLOOP:
                begin
                    ga_reg <= gb_reg;
                    gb_reg <= div_r;
                end
                crtm_pkg::ST_R1G:  tmp_reg <= div_r;
                crtm_pkg::ST_M1G:  m1g_reg <= div_q;
                crtm_pkg::ST_NDIV: n_reg <= div_q[31:0];
                crtm_pkg::ST_AMOD: a_reg <= div_r;
                // wrap-around: b - a, plus m2 when b < a
                crtm_pkg::ST_BMOD: d_reg <= div_r - a_reg + ((div_r < a_reg) ? m2_reg : 32'd0);
                crtm_pkg::ST_DG:
                begin
                    tmp_reg <= div_q[31:0];
                    t_reg   <= 32'd0;
                end
                crtm_pkg::ST_DN:   tmp_reg <= div_r;
                crtm_pkg::ST_U0:
                begin
                    r0_reg  <= div_r;
                    r1e_reg <= n_reg;
                    s0_reg  <= 32'd1;
                    s1_reg  <= 32'd0;
                end
                crtm_pkg::ST_EU:
                begin
                    q_reg   <= div_q[31:0];
                    r0_reg  <= r1e_reg;
                    r1e_reg <= div_r;
                end
                crtm_pkg::ST_ED:
                begin
                    // keep the Bezout coefficient reduced into [0, n)
                    s0_reg <= s1_reg;
                    s1_reg <= s0_reg - div_r + ((s0_reg < div_r) ? n_reg : 32'd0);
                end
                crtm_pkg::ST_TD:   t_reg <= div_r;
                default:           t_reg <= t_reg;
            endcase
        end
        if (mul_done && state_reg == crtm_pkg::ST_OVF)
            lcm_reg <= mul_p[63:0];
    end

    assign s_axis_tready = (state_reg == crtm_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_m_reg, out_r_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### hw/rtl/crtm_checker.sv
// Port checker for the congruence merge block, bound to the top level.
// Uses the assertion macros header; no package use.
`timescale 1ns / 1ps
`include "crt_congruence_merge_top_macros.svh"

module crtm_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    `CRTM_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tuser != 2'd3)
    `CRTM_ASSERT_NOW(a_modulus_nonzero, m_axis_tvalid, m_axis_tdata[127:64] != 64'd0)
    `CRTM_ASSERT_NOW(a_residue_below, m_axis_tvalid, m_axis_tdata[63:0] < m_axis_tdata[127:64])
    `CRTM_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

endmodule

bind crt_congruence_merge_top crtm_checker u_crtm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### verif/tb_crt_congruence_merge_top.sv
// Testbench for the running congruence merge block (CRT, non-coprime moduli).
// Drives a stimulus table, then random congruence sets, and checks every item against a
// predictor or the table's expected result; needs crtm_pkg and crt_congruence_merge_top.
`timescale 1ns / 1ps

module tb_crt_congruence_merge_top;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int RANDOM_ITEMS   = 1300;

    typedef struct packed {
        logic [63:0] res;
        logic [63:0] modulus;
        logic [1:0]  status;
        logic        fin;
    } merge_out_t;

    typedef struct {
        logic [31:0] residue;
        logic [31:0] modulus;
        logic        first;
        logic        last;
        logic        typed;
        merge_out_t  want;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;   // [31:0] residue, [63:32] modulus
    logic         s_axis_tuser;   // [0] first
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;   // [63:0] combined_residue, [127:64] combined_modulus
    logic [1:0]   m_axis_tuser;   // [1:0] status
    logic         m_axis_tlast;

    crt_congruence_merge_top u_dut (.*);

    logic [63:0] run_res;
    logic [63:0] run_mod;
    logic [1:0]  run_status;
    merge_out_t  pending_merges[$];
    stim_row_t   table_rows[$];
    int          mismatches = 0;
    int          items_sent;
    int          items_seen = 0;
    int          nosol_seen = 0;
    int          ovf_seen = 0;
    int          snd_idle;
    int          rcv_idle;
    int          quiet_cycles = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] gcd64(logic [63:0] p, logic [63:0] q);
        logic [63:0] t;
        while (q != 0) begin
            t = p % q;
            p = q;
            q = t;
        end
        return p;
    endfunction

    function automatic logic [63:0] inverse_mod(logic [63:0] u, logic [63:0] n);
        longint r0, r1, s0, s1, q, t;
        if (n <= 1)
            return 0;
        r0 = longint'(u % n);
        r1 = longint'(n);
        s0 = 1;
        s1 = 0;
        while (r1 != 0) begin
            q  = r0 / r1;
            t  = r0 - q * r1;
            r0 = r1;
            r1 = t;
            t  = s0 - q * s1;
            s0 = s1;
            s1 = t;
        end
        s0 = s0 % longint'(n);
        if (s0 < 0)
            s0 += longint'(n);
        return 64'(s0);
    endfunction

    function automatic merge_out_t want_out(logic [63:0] res, logic [63:0] modulus,
                                            logic [1:0] status, logic fin);
        merge_out_t o;
        o.res     = res;
        o.modulus = modulus;
        o.status  = status;
        o.fin     = fin;
        return o;
    endfunction

    function automatic void add_row(logic [31:0] residue, logic [31:0] modulus, logic first,
                                    logic last, logic typed, merge_out_t want);
        stim_row_t row;
        row.residue = residue;
        row.modulus = modulus;
        row.first   = first;
        row.last    = last;
        row.typed   = typed;
        row.want    = want;
        table_rows  = {table_rows, row};
    endfunction

    // advance the running congruence by one item and return its result
    function automatic merge_out_t merge_predict(logic [31:0] r_in, logic [31:0] m_in,
                                                 logic first, logic last);
        logic [63:0] r2, m2, g, m1g, n, a, b, d, t;
        merge_out_t  o;
        r2 = 64'(r_in);
        m2 = (m_in == 0) ? 64'd1 : 64'(m_in);
        if (first) begin
            run_res    = r2 % m2;
            run_mod    = m2;
            run_status = crtm_pkg::STATUS_OK;
        end else if (run_status == crtm_pkg::STATUS_OK) begin
            g = gcd64(run_mod, m2);
            if (run_res % g != r2 % g) begin
                run_status = crtm_pkg::STATUS_NOSOL;
            end else begin
                m1g = run_mod / g;
                if (m1g > 64'hFFFF_FFFF_FFFF_FFFF / m2) begin
                    run_status = crtm_pkg::STATUS_OVF;
                end else begin
                    n = m2 / g;
                    a = run_res % m2;
                    b = r2 % m2;
                    d = (b >= a) ? (b - a) : (b + (m2 - a));
                    t = 0;
                    if (n > 1)
                        t = ((d / g) % n) * inverse_mod(m1g, n) % n;
                    run_res = run_res + run_mod * t;
                    run_mod = m1g * m2;
                end
            end
        end
        o.res     = run_res;
        o.modulus = run_mod;
        o.status  = run_status;
        o.fin     = last;
        return o;
    endfunction

    task automatic send_item(logic [31:0] r, logic [31:0] m, logic first, logic last,
                             logic typed, merge_out_t want);
        merge_out_t got;
        bit idle;
        idle = ($urandom_range(99) < snd_idle);
        if (idle) begin
            s_axis_tvalid <= 1'b0;
            while (idle) begin
                @(posedge clk);
                idle = ($urandom_range(99) < snd_idle);
            end
        end
        s_axis_tdata  <= {m, r};
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        got = merge_predict(r, m, first, last);
        if (typed)
            got = want;
        pending_merges = {pending_merges, got};
        items_sent++;
    endtask

    function automatic logic [31:0] pick_modulus();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(2000, 1);
            4, 5:       return $urandom_range(1 << 20, 1);
            6:          return $urandom_range(40, 0);
            default:    return $urandom;
        endcase
    endfunction

    // receiver: check each item, then roll the stall for the next cycle
    always @(posedge clk) begin
        merge_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            items_seen++;
            if (m_axis_tuser == crtm_pkg::STATUS_NOSOL) nosol_seen++;
            if (m_axis_tuser == crtm_pkg::STATUS_OVF)   ovf_seen++;
            if (pending_merges.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: res=%h mod=%h status=%0d",
                             m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser);
            end else begin
                want = pending_merges.pop_front();
                if (m_axis_tdata[63:0] !== want.res || m_axis_tdata[127:64] !== want.modulus
                    || m_axis_tuser !== want.status || m_axis_tlast !== want.fin) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: want res=%h mod=%h st=%0d last=%b, ",
                                  "got res=%h mod=%h st=%0d last=%b"},
                                 want.res, want.modulus, want.status, want.fin,
                                 m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser,
                                 m_axis_tlast);
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        stim_row_t  row;
        merge_out_t none;
        logic [63:0] x;
        logic [31:0] m, r;
        int set_len, kind;

        none = '0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        run_res = 0;
        run_mod = 1;
        run_status = crtm_pkg::STATUS_OK;
        items_sent = 0;
        snd_idle = 19;
        rcv_idle = 63;

        // merge before any restart: 0 mod 1 absorbs 5 mod 7
        add_row(32'd5, 32'd7, 1'b0, 1'b0, 1'b1,
                want_out(64'd5, 64'd7, crtm_pkg::STATUS_OK, 1'b0));
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
                want_out(64'd0, 64'hFFFF_FFFF, crtm_pkg::STATUS_OK, 1'b1));
        // zero modulus acts as one
        add_row(32'd123, 32'd0, 1'b1, 1'b0, 1'b1,
                want_out(64'd0, 64'd1, crtm_pkg::STATUS_OK, 1'b0));
        add_row(32'hFFFF_FFFF, 32'd1, 1'b1, 1'b1, 1'b1,
                want_out(64'd0, 64'd1, crtm_pkg::STATUS_OK, 1'b1));
        add_row(32'd10, 32'd4, 1'b1, 1'b0, 1'b1,
                want_out(64'd2, 64'd4, crtm_pkg::STATUS_OK, 1'b0));
        // residues disagree mod gcd 2, then the error sticks
        add_row(32'd3, 32'd6, 1'b0, 1'b0, 1'b1,
                want_out(64'd2, 64'd4, crtm_pkg::STATUS_NOSOL, 1'b0));
        add_row(32'd1, 32'd3, 1'b0, 1'b1, 1'b1,
                want_out(64'd2, 64'd4, crtm_pkg::STATUS_NOSOL, 1'b1));
        add_row(32'd2, 32'd4, 1'b1, 1'b0, 1'b1,
                want_out(64'd2, 64'd4, crtm_pkg::STATUS_OK, 1'b0));
        add_row(32'd4, 32'd6, 1'b0, 1'b0, 1'b0, none);
        add_row(32'hFFFF_FFFF, 32'd35, 1'b0, 1'b1, 1'b0, none);
        add_row(32'd0, 32'd0, 1'b0, 1'b0, 1'b0, none);
        // two near-full coprime moduli fit, a third overflows
        add_row(32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, none);
        add_row(32'd7, 32'hFFFF_FFFE, 1'b0, 1'b0, 1'b0, none);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b0, 1'b0, 1'b0, none);
        add_row(32'd9, 32'd11, 1'b0, 1'b1, 1'b0, none);
        add_row(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, 1'b1,
                want_out(64'd0, 64'h8000_0000, crtm_pkg::STATUS_OK, 1'b0));
        add_row(32'h1234_5678, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, none);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i]) begin
            row = table_rows[i];
            send_item(row.residue, row.modulus, row.first, row.last, row.typed, row.want);
        end

        while (items_sent < RANDOM_ITEMS + table_rows.size()) begin
            if (items_sent < 450) begin
                snd_idle = 19; rcv_idle = 63;
            end else if (items_sent < 900) begin
                snd_idle = 63; rcv_idle = 19;
            end else begin
                snd_idle = 0; rcv_idle = 0;
            end
            kind = $urandom_range(99);
            set_len = $urandom_range(5, 1);
            x = {$urandom, $urandom};
            for (int k = 0; k < set_len; k++) begin
                if (kind < 70) begin
                    // consistent set: every residue comes from one solution x
                    m = pick_modulus();
                    r = (m == 0) ? $urandom : 32'(x % 64'(m));
                    send_item(r, m, k == 0, k == set_len - 1, 1'b0, none);
                end else if (kind < 80) begin
                    // large moduli, likely to overflow
                    m = $urandom | 32'h8000_0001;
                    send_item($urandom, m, k == 0, k == set_len - 1, 1'b0, none);
                end else if (kind < 90) begin
                    // broken set with random residues
                    send_item($urandom, pick_modulus(), k == 0, k == set_len - 1, 1'b0, none);
                end else begin
                    send_item($urandom, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'b0, none);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_merges.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Sent %0d congruences, checked %0d results (%0d no-solution, %0d overflow).",
                 items_sent, items_seen, nosol_seen, ovf_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && pending_merges.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
